@@ rtl/rfr_pkg.sv @@
// ----------------------------------------------------------------------------
// RS-485 frame receiver package
// Shared types and codes for the frame receiver: parser phases, result kinds,
// register indexes and the result record.
// ----------------------------------------------------------------------------
package rfr_pkg;

  localparam int unsigned HDR_LEN = 7;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_DATA = 2'd0;
  localparam kind_t KIND_GOOD = 2'd1;
  localparam kind_t KIND_BAD  = 2'd2;

  typedef logic cfg_idx_t;
  localparam cfg_idx_t CFG_SYNC_FIRST  = 1'b0;
  localparam cfg_idx_t CFG_SYNC_SECOND = 1'b1;

  typedef enum logic [2:0] {
    PH_HUNT     = 3'd0,
    PH_SYNC2    = 3'd1,
    PH_HEADER   = 3'd2,
    PH_PAYLOAD  = 3'd3,
    PH_CHECK_HI = 3'd4,
    PH_CHECK_LO = 3'd5
  } phase_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload_byte;
    logic [15:0] addr_word_a;
    logic [15:0] addr_word_b;
    logic [7:0]  control_code;
    logic [7:0]  function_code;
    logic [7:0]  payload_length;
  } result_t;

endpackage

@@ rtl/rfr_parser.sv @@
// ----------------------------------------------------------------------------
// Frame parser
// Holds the frame state (phase, header bytes, byte count and running sum) and
// turns each received byte combinationally into at most one result.
// ----------------------------------------------------------------------------
module rfr_parser
  import rfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  logic [7:0] rx_byte,
  input  logic [7:0] sync_first,
  input  logic [7:0] sync_second,
  output logic       res_valid,
  output result_t    res
);

  phase_t      phase_r, phase_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic [7:0]  count_r, count_nxt;
  logic [7:0]  hdr_r [HDR_LEN];
  logic        hdr_we;
  logic [15:0] sum_add;
  logic [7:0]  count_inc;

  assign sum_add   = sum_r + {8'd0, rx_byte};
  assign count_inc = count_r + 8'd1;

  always_comb begin
    phase_nxt = phase_r;
    sum_nxt   = sum_r;
    count_nxt = count_r;
    hdr_we    = 1'b0;
    unique case (phase_r)
      PH_HUNT: begin
        if (rx_byte == sync_first) begin
          sum_nxt   = sum_add;
          phase_nxt = PH_SYNC2;
        end
      end
      PH_SYNC2: begin
        if (rx_byte == sync_second) begin
          sum_nxt   = sum_add;
          phase_nxt = PH_HEADER;
          count_nxt = 8'd0;
        end else begin
          sum_nxt   = 16'd0;
          phase_nxt = PH_HUNT;
        end
      end
      PH_HEADER: begin
        hdr_we  = 1'b1;
        sum_nxt = sum_add;
        if (count_inc >= 8'(HDR_LEN)) begin
          count_nxt = 8'd0;
          phase_nxt = (rx_byte == 8'd0) ? PH_CHECK_HI : PH_PAYLOAD;
        end else begin
          count_nxt = count_inc;
        end
      end
      PH_PAYLOAD: begin
        sum_nxt   = sum_add;
        count_nxt = count_inc;
        if (count_inc == hdr_r[HDR_LEN-1]) begin
          phase_nxt = PH_CHECK_HI;
        end
      end
      PH_CHECK_HI: begin
        if (rx_byte == sum_r[15:8]) begin
          phase_nxt = PH_CHECK_LO;
        end else begin
          sum_nxt   = 16'd0;
          phase_nxt = PH_HUNT;
        end
      end
      PH_CHECK_LO: begin
        sum_nxt   = 16'd0;
        phase_nxt = PH_HUNT;
      end
      default: begin
        sum_nxt   = 16'd0;
        phase_nxt = PH_HUNT;
      end
    endcase
  end

  always_comb begin
    res_valid          = 1'b0;
    res.kind           = KIND_DATA;
    res.payload_byte   = 8'd0;
    res.addr_word_a    = {hdr_r[0], hdr_r[1]};
    res.addr_word_b    = {hdr_r[2], hdr_r[3]};
    res.control_code   = hdr_r[4];
    res.function_code  = hdr_r[5];
    res.payload_length = hdr_r[6];
    unique case (phase_r)
      PH_PAYLOAD: begin
        res_valid        = 1'b1;
        res.kind         = KIND_DATA;
        res.payload_byte = rx_byte;
      end
      PH_CHECK_HI: begin
        res_valid = (rx_byte != sum_r[15:8]);
        res.kind  = KIND_BAD;
      end
      PH_CHECK_LO: begin
        res_valid = 1'b1;
        res.kind  = (rx_byte == sum_r[7:0]) ? KIND_GOOD : KIND_BAD;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      sum_r   <= 16'd0;
      count_r <= 8'd0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      sum_r   <= sum_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < HDR_LEN; i++) begin
      if (fire && hdr_we && (count_r[2:0] == 3'(i))) begin
        hdr_r[i] <= rx_byte;
      end
    end
  end

endmodule

@@ rtl/rfr_out_reg.sv @@
// ----------------------------------------------------------------------------
// Result register
// Holds one result transaction until the receiver takes it, and reports when
// a new result can be loaded in the same cycle.
// ----------------------------------------------------------------------------
module rfr_out_reg
  import rfr_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load_valid,
  input  result_t load_data,
  input  logic    out_stall,
  output logic    out_valid,
  output result_t out_data,
  output logic    ready
);

  logic    valid_r, valid_nxt;
  result_t data_r;

  assign ready     = !valid_r || !out_stall;
  assign valid_nxt = ready ? load_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && load_valid) begin
      data_r <= load_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

@@ rtl/rs485_frame_receiver.sv @@
// ----------------------------------------------------------------------------
// RS-485 frame receiver
// Hunts for a two-byte sync pattern, stores a seven-byte header, passes the
// payload through and closes each frame with a checksum verdict.
// ----------------------------------------------------------------------------
//  Channel  Direction  Ports
//  in       input      in_valid, in_stall, in_rx_byte
//  out      output     out_valid, out_stall, out_kind .. out_payload_length
//  cfg      input      cfg_we, cfg_index, cfg_data
//
// One byte is taken per cycle unless the result register is full and stalled:
// a byte waits in the input register, and as it leaves, the parser updates its
// state and loads the result register, which drives the output.
// in_stall rises only while the result register is full and stalled.
// Reset is synchronous and leaves the parser hunting for the first sync byte.
// ----------------------------------------------------------------------------
module rs485_frame_receiver
  import rfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_payload_byte,
  output logic [15:0] out_addr_word_a,
  output logic [15:0] out_addr_word_b,
  output logic [7:0]  out_control_code,
  output logic [7:0]  out_function_code,
  output logic [7:0]  out_payload_length,
  input  logic        cfg_we,
  input  cfg_idx_t    cfg_index,
  input  logic [7:0]  cfg_data
);

  logic       in_valid_r, in_valid_nxt;
  logic [7:0] in_byte_r;
  logic [7:0] sync_first_r;
  logic [7:0] sync_second_r;
  logic       in_accept;
  logic       proc_fire;
  logic       out_ready;
  logic       res_valid;
  result_t    res;
  result_t    out_data;

  assign in_stall     = in_valid_r && !out_ready;
  assign in_accept    = in_valid && !in_stall;
  assign proc_fire    = in_valid_r && out_ready;
  assign in_valid_nxt = in_accept ? 1'b1 : (proc_fire ? 1'b0 : in_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_byte_r <= in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= 8'hAA;
      sync_second_r <= 8'h55;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SYNC_FIRST:  sync_first_r  <= cfg_data;
        CFG_SYNC_SECOND: sync_second_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  rfr_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (proc_fire),
    .rx_byte     (in_byte_r),
    .sync_first  (sync_first_r),
    .sync_second (sync_second_r),
    .res_valid   (res_valid),
    .res         (res)
  );

  rfr_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (proc_fire && res_valid),
    .load_data  (res),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .ready      (out_ready)
  );

  assign out_kind           = out_data.kind;
  assign out_payload_byte   = out_data.payload_byte;
  assign out_addr_word_a    = out_data.addr_word_a;
  assign out_addr_word_b    = out_data.addr_word_b;
  assign out_control_code   = out_data.control_code;
  assign out_function_code  = out_data.function_code;
  assign out_payload_length = out_data.payload_length;

`ifndef SYNTHESIS
  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind == KIND_DATA || out_kind == KIND_GOOD || out_kind == KIND_BAD))
    else $error("result kind out of range");

  a_verdict_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != KIND_DATA) |-> (out_payload_byte == 8'd0))
    else $error("verdict carries a payload byte");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a blocked result");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (proc_fire && res_valid) |=> out_valid)
    else $error("result transaction lost");
`endif

endmodule

@@ test/rs485_frame_receiver_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RS-485 frame receiver testbench
// Streams framed byte sequences (good frames, corrupted checks, broken sync
// pairs and line noise) into the receiver under several sync settings and
// flow-control regimes. Every accepted input transaction updates a frame
// predictor, and each result transaction is compared field by field with
// the oldest predicted result.
// ----------------------------------------------------------------------------
module rs485_frame_receiver_test;
  import rfr_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 6;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_BYTES  = 100;
  localparam logic [7:0] SYNC_FIRST_RESET  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND_RESET = 8'h55;

  typedef enum int {FR_GOOD, FR_BAD_HI, FR_BAD_LO, FR_BAD_SYNC} flaw_t;

  class frame_predictor;
    logic [7:0]  sync_a;
    logic [7:0]  sync_b;
    phase_t      phase;
    logic [7:0]  hdr [HDR_LEN];
    logic [7:0]  count;
    logic [15:0] sum;
    result_t     awaited[$];
    int          mismatch_count;

    function new();
      sync_a = SYNC_FIRST_RESET;
      sync_b = SYNC_SECOND_RESET;
      phase = PH_HUNT;
      foreach (hdr[i]) hdr[i] = 8'h00;
      count = 8'h00;
      sum = 16'h0000;
      mismatch_count = 0;
    endfunction

    function void set_sync(cfg_idx_t idx, logic [7:0] val);
      if (idx == CFG_SYNC_FIRST) sync_a = val;
      else sync_b = val;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void restart();
      phase = PH_HUNT;
      sum = 16'h0000;
    endfunction

    function void note_byte(logic [7:0] c);
      bit         emit;
      kind_t      k;
      logic [7:0] d;
      emit = 1'b0;
      k = KIND_DATA;
      d = 8'h00;
      case (phase)
        PH_HUNT: begin
          if (c == sync_a) begin
            sum += {8'h00, c};
            phase = PH_SYNC2;
          end
        end
        PH_SYNC2: begin
          if (c == sync_b) begin
            sum += {8'h00, c};
            phase = PH_HEADER;
            count = 8'h00;
          end else begin
            restart();
          end
        end
        PH_HEADER: begin
          hdr[count[2:0]] = c;
          sum += {8'h00, c};
          count++;
          if (count >= 8'(HDR_LEN)) begin
            count = 8'h00;
            phase = (hdr[HDR_LEN-1] == 8'h00) ? PH_CHECK_HI : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          sum += {8'h00, c};
          count++;
          if (count == hdr[HDR_LEN-1]) phase = PH_CHECK_HI;
          emit = 1'b1;
          d = c;
        end
        PH_CHECK_HI: begin
          if (c == sum[15:8]) begin
            phase = PH_CHECK_LO;
          end else begin
            emit = 1'b1;
            k = KIND_BAD;
            restart();
          end
        end
        PH_CHECK_LO: begin
          emit = 1'b1;
          k = (c == sum[7:0]) ? KIND_GOOD : KIND_BAD;
          restart();
        end
        default: restart();
      endcase
      if (emit)
        awaited.push_back({k, d, hdr[0], hdr[1], hdr[2], hdr[3], hdr[4], hdr[5], hdr[6]});
    endfunction

    function void check_result(result_t got);
      result_t want;
      bit      stray;
      string   exp_s;
      string   got_s;
      stray = (awaited.size() == 0);
      want = stray ? result_t'(0) : awaited.pop_front();
      if (stray || got.kind !== want.kind || got.payload_byte !== want.payload_byte ||
          got.addr_word_a !== want.addr_word_a || got.addr_word_b !== want.addr_word_b ||
          got.control_code !== want.control_code ||
          got.function_code !== want.function_code ||
          got.payload_length !== want.payload_length) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          exp_s = $sformatf("kind=%0d byte=%h a=%h b=%h ctl=%h fn=%h len=%h",
                            want.kind, want.payload_byte, want.addr_word_a,
                            want.addr_word_b, want.control_code, want.function_code,
                            want.payload_length);
          got_s = $sformatf("kind=%0d byte=%h a=%h b=%h ctl=%h fn=%h len=%h",
                            got.kind, got.payload_byte, got.addr_word_a,
                            got.addr_word_b, got.control_code, got.function_code,
                            got.payload_length);
          $display("mismatch%s: expected %s, got %s",
                   stray ? " (none expected)" : "", exp_s, got_s);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_payload_byte;
  logic [15:0] out_addr_word_a;
  logic [15:0] out_addr_word_b;
  logic [7:0]  out_control_code;
  logic [7:0]  out_function_code;
  logic [7:0]  out_payload_length;
  logic        cfg_we = 1'b0;
  cfg_idx_t    cfg_index = CFG_SYNC_FIRST;
  logic [7:0]  cfg_data = 8'h00;

  frame_predictor frames;
  logic [7:0]     sync_first_val = SYNC_FIRST_RESET;
  logic [7:0]     sync_second_val = SYNC_SECOND_RESET;
  int             idle_pct = 0;
  int             stall_pct = 0;
  int             bytes_sent = 0;
  int             cycle_count = 0;
  logic           hold_armed = 1'b0;
  bit             hold_taken = 1'b0;
  int             hold_left = 0;

  rs485_frame_receiver dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_payload_byte   (out_payload_byte),
    .out_addr_word_a    (out_addr_word_a),
    .out_addr_word_b    (out_addr_word_b),
    .out_control_code   (out_control_code),
    .out_function_code  (out_function_code),
    .out_payload_length (out_payload_length),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("rs485_frame_receiver test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      frames.check_result(result_t'({out_kind, out_payload_byte, out_addr_word_a,
                                     out_addr_word_b, out_control_code,
                                     out_function_code, out_payload_length}));
    if (hold_armed && !hold_taken) begin
      hold_left = HOLD_CYCLES;
      hold_taken = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    frames.note_byte(b);
    bytes_sent++;
  endtask

  // A negative fill gives random header and payload bytes; the length byte is plen.
  task automatic send_frame(input int plen, input flaw_t flaw, input int fill);
    logic [15:0] sum;
    logic [7:0]  b;
    logic [7:0]  bad;
    sum = 16'(sync_first_val);
    send_byte(sync_first_val);
    if (flaw == FR_BAD_SYNC) begin
      do b = 8'($urandom_range(0, 255)); while (b == sync_second_val);
      send_byte(b);
      return;
    end
    send_byte(sync_second_val);
    sum += {8'h00, sync_second_val};
    for (int i = 0; i < HDR_LEN + plen; i++) begin
      if (i == HDR_LEN - 1) b = plen[7:0];
      else if (fill < 0) b = 8'($urandom_range(0, 255));
      else b = fill[7:0];
      send_byte(b);
      sum += {8'h00, b};
    end
    bad = 8'($urandom_range(1, 255));
    send_byte((flaw == FR_BAD_HI) ? (sum[15:8] ^ bad) : sum[15:8]);
    if (flaw != FR_BAD_HI)
      send_byte((flaw == FR_BAD_LO) ? (sum[7:0] ^ bad) : sum[7:0]);
  endtask

  task automatic write_cfg(input cfg_idx_t idx, input logic [7:0] val);
    in_valid <= 1'b0;
    while (frames.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    frames.set_sync(idx, val);
    if (idx == CFG_SYNC_FIRST) sync_first_val = val;
    else sync_second_val = val;
  endtask

  task automatic random_traffic(input int target);
    int sel;
    int plen;
    while (bytes_sent < target) begin
      sel = $urandom_range(0, 99);
      plen = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 12);
      if (sel < 65) send_frame(plen, FR_GOOD, -1);
      else if (sel < 77) send_frame(plen, FR_BAD_HI, -1);
      else if (sel < 89) send_frame(plen, FR_BAD_LO, -1);
      else if (sel < 95) send_frame(plen, FR_BAD_SYNC, -1);
      else repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    logic [7:0] shared;
    frames = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_byte(8'h00);
    send_byte(sync_first_val);
    send_byte(sync_first_val);
    send_frame(0, FR_GOOD, 8'h00);
    send_frame(1, FR_BAD_HI, 8'hFF);

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          write_cfg(CFG_SYNC_FIRST, 8'h00);
          write_cfg(CFG_SYNC_SECOND, 8'hFF);
        end
        1: begin
          write_cfg(CFG_SYNC_FIRST, 8'hFF);
          write_cfg(CFG_SYNC_SECOND, 8'h00);
        end
        2: begin
          shared = 8'($urandom_range(0, 255));
          write_cfg(CFG_SYNC_FIRST, shared);
          write_cfg(CFG_SYNC_SECOND, shared);
        end
        default: begin
          write_cfg(CFG_SYNC_FIRST, 8'($urandom_range(0, 255)));
          write_cfg(CFG_SYNC_SECOND, 8'($urandom_range(0, 255)));
        end
      endcase
      idle_pct = (p == 1 || p == 3) ? ((p == 1) ? 85 : 33) : 0;
      stall_pct <= (p == 2) ? 85 : ((p == 3) ? 33 : 0);
      if (p == 0) begin
        hold_armed <= 1'b1;
        send_frame(255, FR_GOOD, -1);
      end
      random_traffic(bytes_sent + PHASE_BYTES);
    end

    in_valid <= 1'b0;
    while (frames.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (frames.mismatch_count == 0 && frames.pending() == 0)
      $display("rs485_frame_receiver test passed");
    else
      $display("rs485_frame_receiver test failed");
    $finish;
  end

endmodule
